// ----- hdl/pcxrle_pkg.sv -----
// Shared types and constants for the PCX run-length decoder.
`timescale 1ns / 1ps

package pcxrle_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0]  RUN_MARK      = 8'd192;
   localparam logic [7:0]  BYTE_MAX      = 8'd255;
   localparam logic [16:0] MAX_PIXELS    = 17'd65536;
   localparam logic [16:0] LIMIT_RESET   = 17'd64000;

   // One classified byte on its way to the pixel generator.
   typedef struct packed {
      logic [7:0] value;  // pixel value to repeat
      logic [5:0] count;  // pixels to emit, zero for a run header
      logic       sof;    // clear the image state first
   } cmd_type;

endpackage

// ----- hdl/pcx_rle_decoder.sv -----
// Top level of the PCX run-length decoder.
`timescale 1ns / 1ps
//
// Compressed bytes enter through a queue-style write side: push with the
// byte and start_of_image, taken at an edge where full is low. Pixels leave
// through a queue-style read side: while empty is low the oldest pixel,
// its index, last_of_run and image_complete are shown; pop takes it.
// The csr channel (valid/ready, ready always high) writes pixel_limit;
// write it only while the decoder is idle.
// A classifier takes one byte per cycle while full is low and pushes a
// command into a short queue. The pixel generator pops a command once it
// has no pixels left, headers included, then emits one pixel per cycle
// while its output register is empty or being popped, and never while it
// pops. A byte's first pixel passes the queue, the run registers and the
// output register. The generator loop sets the sustained rate.
// Reset empties the queue and output, clears run and image state, and sets
// pixel_limit to 64000. When pop stays low the output word holds and the
// generator stops emitting; before image completion the queue fills, full rises.

module pcx_rle_decoder
   import pcxrle_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // compressed byte input
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_image,
   // pixel output
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_pixel_value,
   output logic [15:0] rsp_pixel_index,
   output logic        rsp_last_of_run,
   output logic        rsp_image_complete,
   // pixel_limit register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_wdata
);

   logic [16:0] pixel_limit_ff;
   logic        q_push, q_pop, q_full, q_valid;
   cmd_type     push_cmd, head_cmd;

   // Always take register writes; hold the limit otherwise.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         pixel_limit_ff <= csr_wdata;
      end
   end

   assign req_full = q_full;

   pcxrle_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_data_byte      (req_data_byte),
      .req_start_of_image (req_start_of_image),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_cmd              (push_cmd)
   );

   pcxrle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .valid    (q_valid),
      .head_cmd (head_cmd)
   );

   pcxrle_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pixel_limit        (pixel_limit_ff),
      .q_valid            (q_valid),
      .q_cmd              (head_cmd),
      .q_pop              (q_pop),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_pixel_index    (rsp_pixel_index),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_image_complete (rsp_image_complete)
   );

endmodule

// ----- hdl/pcxrle_front.sv -----
// Byte classifier: tracks run headers and turns each byte into a command.
`timescale 1ns / 1ps

module pcxrle_front
   import pcxrle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_data_byte,
   input  logic       req_start_of_image,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);

   logic       awaiting_ff, awaiting_in;
   logic [5:0] pending_ff, pending_in;
   logic       awaiting_now;
   logic [5:0] pending_now;

   always_comb begin
      awaiting_now = req_start_of_image ? 1'b0 : awaiting_ff;
      pending_now  = req_start_of_image ? 6'd0 : pending_ff;
      q_push       = req_push && !q_full;
      q_cmd.value  = req_data_byte;
      q_cmd.sof    = req_start_of_image;
      q_cmd.count  = 6'd1;
      awaiting_in  = awaiting_ff;
      pending_in   = pending_ff;
      if (awaiting_now) begin
         // value byte of a run
         q_cmd.count = pending_now;
         awaiting_in = 1'b0;
         pending_in  = 6'd0;
      end else if (req_data_byte inside {[RUN_MARK:BYTE_MAX]}) begin
         // header: emits nothing, but the back end still checks completion
         q_cmd.count = 6'd0;
         awaiting_in = 1'b1;
         pending_in  = req_data_byte[5:0];
      end else begin
         awaiting_in = 1'b0;
         pending_in  = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b0;
         pending_ff  <= 6'd0;
      end else if (q_push) begin
         awaiting_ff <= awaiting_in;
         pending_ff  <= pending_in;
      end
   end

endmodule

// ----- hdl/pcxrle_queue.sv -----
// Short command queue between the classifier and the pixel generator.
`timescale 1ns / 1ps

module pcxrle_queue
   import pcxrle_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    valid,
   output cmd_type head_cmd
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   cmd_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   always_comb begin
      full      = (count_ff == FULL_CNT);
      valid     = (count_ff != '0);
      head_cmd  = mem_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && valid;
      wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- hdl/pcxrle_back.sv -----
// Pixel generator: expands commands into indexed pixels up to the limit.
`timescale 1ns / 1ps

module pcxrle_back
   import pcxrle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [16:0] pixel_limit,
   input  logic        q_valid,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [7:0]  rsp_pixel_value,
   output logic [15:0] rsp_pixel_index,
   output logic        rsp_last_of_run,
   output logic        rsp_image_complete
);

   logic [16:0] written_ff, written_in;
   logic        finished_ff, finished_in;
   logic [5:0]  remain_ff, remain_in;
   logic [7:0]  value_ff, value_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_value_ff;
   logic [15:0] out_index_ff;
   logic        out_last_ff, out_complete_ff;

   logic [16:0] limit_eff;
   logic [16:0] written_clr;
   logic        finished_clr, finished_chk;
   logic        idle, emit, last_image, last_run;

   always_comb begin
      limit_eff    = (pixel_limit > MAX_PIXELS) ? MAX_PIXELS : pixel_limit;
      idle         = (remain_ff == 6'd0);
      q_pop        = idle && q_valid;
      emit         = !idle && (!out_valid_ff || rsp_pop);
      last_image   = ({1'b0, written_ff} + 18'd1) == {1'b0, limit_eff};
      last_run     = (remain_ff == 6'd1) || last_image;

      written_clr  = q_cmd.sof ? 17'd0 : written_ff;
      finished_clr = q_cmd.sof ? 1'b0 : finished_ff;
      finished_chk = finished_clr || (written_clr >= limit_eff);

      written_in   = written_ff;
      finished_in  = finished_ff;
      remain_in    = remain_ff;
      value_in     = value_ff;
      if (q_pop) begin
         written_in  = written_clr;
         finished_in = finished_chk;
         remain_in   = finished_chk ? 6'd0 : q_cmd.count;
         value_in    = q_cmd.value;
      end else if (emit) begin
         written_in  = written_ff + 17'd1;
         finished_in = finished_ff || last_image;
         remain_in   = last_image ? 6'd0 : remain_ff - 6'd1;
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= 17'd0;
         finished_ff  <= 1'b0;
         remain_ff    <= 6'd0;
         out_valid_ff <= 1'b0;
      end else begin
         written_ff   <= written_in;
         finished_ff  <= finished_in;
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (emit) begin
         out_value_ff    <= value_ff;
         out_index_ff    <= written_ff[15:0];
         out_last_ff     <= last_run;
         out_complete_ff <= last_image;
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_pixel_value    = out_value_ff;
   assign rsp_pixel_index    = out_index_ff;
   assign rsp_last_of_run    = out_last_ff;
   assign rsp_image_complete = out_complete_ff;

endmodule

// ----- hdl/pcxrle_checker.sv -----
// Port-level checks for the PCX run-length decoder, bound to the top level.
`timescale 1ns / 1ps

module pcxrle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_pixel_value,
   input logic [15:0] rsp_pixel_index,
   input logic        rsp_last_of_run,
   input logic        rsp_image_complete
);

   // Reset leaves no pixel pending and the input open.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("output not empty after reset");

   a_reset_open: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full after reset");

   // The final pixel of an image also ends its run.
   a_complete_ends_run: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_image_complete) |-> rsp_last_of_run)
      else $error("image_complete without last_of_run");

   // A stalled word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_pixel_value)
         && $stable(rsp_pixel_index) && $stable(rsp_last_of_run)
         && $stable(rsp_image_complete)))
      else $error("stalled output word changed");

endmodule

bind pcx_rle_decoder pcxrle_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_full           (req_full),
   .rsp_empty          (rsp_empty),
   .rsp_pop            (rsp_pop),
   .rsp_pixel_value    (rsp_pixel_value),
   .rsp_pixel_index    (rsp_pixel_index),
   .rsp_last_of_run    (rsp_last_of_run),
   .rsp_image_complete (rsp_image_complete)
);
